// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define RMSM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define RMSM_ASSERT_IMP(label, cond, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rmsm_pkg.sv =====
// Shared constants and types of the RMS sound level meter.
package rmsm_pkg;

  localparam int unsigned BLOCK_LEN = 1024;
  localparam int unsigned COUNT_CAP = (BLOCK_LEN > 2047) ? 2047 : BLOCK_LEN;
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned SUM_W     = 56;
  localparam int unsigned MUL_W     = 32;

  localparam logic [SUM_W-1:0] SUM_MAX         = {SUM_W{1'b1}};
  localparam logic [MUL_W-1:0] TEN_LOG10_2_Q24 = 32'd50504453;
  localparam logic [23:0]      FS_LOG2_Q16     = 24'(46 << 16);

  typedef enum logic [1:0] {
    REG_SAMPLE_SHIFT = 2'd0,
    REG_CALIBRATION  = 2'd1,
    REG_FLOOR        = 2'd2,
    REG_CEILING      = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [2*MUL_W-1:0] product;
  } mul_rsp_t;

endpackage

// ===== hw/rtl/block_rms_sound_level_meter.sv =====
// Top level of the block RMS sound level meter.
//
//   channel   direction  handshake                 payload
//   in        sink       in_valid_i / in_stall_o   sample_word_i, last_in_block_i
//   out       source     out_valid_o / out_stall_i level_q8_o, nonzero_count_o,
//                                                  silent_block_o
//   config    APB slave  psel/penable/pwrite       paddr, pwdata, prdata
//
// An item whose sample is zero (or past the count cap) is taken without a product; a
// nonzero sample is squared by the 32-step shift-add multiplier.
// An end-of-block item with a nonzero count adds two one-bit-a-cycle
// normalizations and 33 serial products (two 16-step log2 loops and the dB scale).
// in_stall_o is high while an item is at work; a finished result waits in the
// output register and the next item is taken meanwhile. Reset restores the
// register defaults and clears the accumulators.
module block_rms_sound_level_meter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic signed [31:0] sample_word_i,
  input  logic        last_in_block_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] level_q8_o,
  output logic [10:0] nonzero_count_o,
  output logic        silent_block_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rmsm_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_CHECK,
    ST_NORM,
    ST_LOG,
    ST_DMUL,
    ST_REPORT
  } state_e;

  // Configuration registers
  logic [4:0] shift_q;
  logic [7:0] cal_q;
  logic [7:0] floor_q;
  logic [7:0] ceil_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 5'd8;
      cal_q   <= 8'd120;
      floor_q <= 8'd20;
      ceil_q  <= 8'd120;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[3:2]))
        REG_SAMPLE_SHIFT: shift_q <= pwdata[4:0];
        REG_CALIBRATION:  cal_q   <= pwdata[7:0];
        REG_FLOOR:        floor_q <= pwdata[7:0];
        REG_CEILING:      ceil_q  <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      REG_SAMPLE_SHIFT: prdata = {27'd0, shift_q};
      REG_CALIBRATION:  prdata = {24'd0, cal_q};
      REG_FLOOR:        prdata = {24'd0, floor_q};
      REG_CEILING:      prdata = {24'd0, ceil_q};
    endcase
  end

  // Datapath state
  state_e             state_q;
  logic               last_q;
  logic [SUM_W-1:0]   sum_q;
  logic [CNT_W-1:0]   count_q;
  logic [63:0]        norm_q;
  logic [5:0]         exp_q;
  logic [15:0]        frac_q;
  logic [3:0]         bit_q;
  logic               phase_cnt_q;
  logic [21:0]        log_sum_q;
  logic               d_neg_q;
  logic [19:0]        db_q;
  logic               mul_start_q;
  logic [MUL_W-1:0]   mul_a_q;
  logic [MUL_W-1:0]   mul_b_q;
  logic               out_valid_q;
  logic [15:0]        level_q;
  logic [CNT_W-1:0]   nz_q;
  logic               silent_q;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  assign mul_req.start = mul_start_q;
  assign mul_req.a     = mul_a_q;
  assign mul_req.b     = mul_b_q;

  rmsm_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // Sample alignment
  logic signed [31:0] sample_s;
  logic [31:0]        sample_mag;
  logic               sample_use;

  assign sample_s   = sample_word_i >>> shift_q;
  assign sample_mag = sample_s[31] ? (~sample_s + 32'd1) : sample_s;
  assign sample_use = (sample_s != 32'sd0) && (count_q < CNT_W'(COUNT_CAP));

  // Saturating accumulate
  logic [63:0]      sum_ext;
  logic [SUM_W-1:0] sum_next;

  assign sum_ext  = {8'd0, sum_q} + mul_rsp.product;
  assign sum_next = (sum_ext > {8'd0, SUM_MAX}) ? SUM_MAX : sum_ext[SUM_W-1:0];

  // One log2 fraction bit per squaring
  logic [31:0] y_next;
  logic [15:0] frac_next;
  logic [21:0] log_now;
  logic [23:0] d_val;
  logic [23:0] d_mag;

  always_comb begin
    y_next         = mul_rsp.product[63] ? mul_rsp.product[63:32] : mul_rsp.product[62:31];
    frac_next      = frac_q;
    frac_next[bit_q] = mul_rsp.product[63];
    log_now        = {exp_q, frac_next};
    d_val          = {2'b00, log_sum_q} - {2'b00, log_now} - FS_LOG2_Q16;
    d_mag          = d_val[23] ? (~d_val + 24'd1) : d_val;
  end

  // Round the scaled product to 1/256 dB, halves toward +inf
  logic [63:0] p_signed;
  logic [63:0] p_biased;

  assign p_signed = d_neg_q ? (64'd0 - mul_rsp.product) : mul_rsp.product;
  assign p_biased = p_signed + 64'h0000_0000_8000_0000;

  // Offset and clamp
  logic signed [20:0] level_raw;
  logic signed [20:0] floor_s;
  logic signed [20:0] ceil_s;
  logic signed [20:0] level_f;
  logic signed [20:0] level_c;

  always_comb begin
    level_raw = $signed({5'd0, cal_q, 8'd0}) + $signed({db_q[19], db_q});
    floor_s   = $signed({5'd0, floor_q, 8'd0});
    ceil_s    = $signed({5'd0, ceil_q, 8'd0});
    level_f   = (level_raw < floor_s) ? floor_s : level_raw;
    level_c   = (level_f > ceil_s) ? ceil_s : level_f;
  end

  logic out_free;
  logic out_load;
  logic mul_kick;

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = out_free &&
                    ((state_q == ST_REPORT) || (state_q == ST_CHECK && count_q == '0));

  // Start a product when an item, a normalized mantissa, the next squaring or the dB scale is ready
  always_comb begin
    unique case (state_q)
      ST_IDLE: mul_kick = in_valid_i && sample_use;
      ST_NORM: mul_kick = norm_q[63];
      ST_LOG:  mul_kick = mul_rsp.done && ((bit_q != 4'd0) || phase_cnt_q);
      default: mul_kick = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= 1'b0;
      sum_q       <= '0;
      count_q     <= '0;
      norm_q      <= '0;
      exp_q       <= '0;
      frac_q      <= '0;
      bit_q       <= '0;
      phase_cnt_q <= 1'b0;
      log_sum_q   <= '0;
      d_neg_q     <= 1'b0;
      db_q        <= '0;
      mul_start_q <= 1'b0;
      mul_a_q     <= '0;
      mul_b_q     <= '0;
      out_valid_q <= 1'b0;
      level_q     <= '0;
      nz_q        <= '0;
      silent_q    <= 1'b0;
    end else begin
      mul_start_q <= mul_kick;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            last_q <= last_in_block_i;
            if (sample_use) begin
              mul_a_q     <= sample_mag;
              mul_b_q     <= sample_mag;
              state_q     <= ST_SQUARE;
            end else if (last_in_block_i) begin
              state_q <= ST_CHECK;
            end
          end
        end
        ST_SQUARE: begin
          if (mul_rsp.done) begin
            sum_q   <= sum_next;
            count_q <= count_q + CNT_W'(1);
            state_q <= last_q ? ST_CHECK : ST_IDLE;
          end
        end
        ST_CHECK: begin
          if (count_q == '0) begin
            if (out_free) begin
              level_q     <= {floor_q, 8'd0};
              nz_q        <= '0;
              silent_q    <= 1'b1;
              state_q     <= ST_IDLE;
            end
          end else begin
            norm_q      <= {8'd0, sum_q};
            exp_q       <= '1;
            phase_cnt_q <= 1'b0;
            state_q     <= ST_NORM;
          end
        end
        ST_NORM: begin
          // Shift left one bit a cycle until the leading one reaches the top.
          if (norm_q[63]) begin
            mul_a_q     <= norm_q[63:32];
            mul_b_q     <= norm_q[63:32];
            frac_q      <= '0;
            bit_q       <= '1;
            state_q     <= ST_LOG;
          end else begin
            norm_q <= {norm_q[62:0], 1'b0};
            exp_q  <= exp_q - 6'd1;
          end
        end
        ST_LOG: begin
          if (mul_rsp.done) begin
            frac_q <= frac_next;
            if (bit_q != 4'd0) begin
              bit_q       <= bit_q - 4'd1;
              mul_a_q     <= y_next;
              mul_b_q     <= y_next;
            end else if (!phase_cnt_q) begin
              log_sum_q   <= log_now;
              norm_q      <= {{(64-CNT_W){1'b0}}, count_q};
              exp_q       <= '1;
              phase_cnt_q <= 1'b1;
              state_q     <= ST_NORM;
            end else begin
              d_neg_q     <= d_val[23];
              mul_a_q     <= {8'd0, d_mag};
              mul_b_q     <= TEN_LOG10_2_Q24;
              state_q     <= ST_DMUL;
            end
          end
        end
        ST_DMUL: begin
          if (mul_rsp.done) begin
            db_q    <= p_biased[51:32];
            state_q <= ST_REPORT;
          end
        end
        ST_REPORT: begin
          if (out_free) begin
            level_q     <= level_c[15:0];
            nz_q        <= count_q;
            silent_q    <= 1'b0;
            sum_q       <= '0;
            count_q     <= '0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign level_q8_o      = level_q;
  assign nonzero_count_o = nz_q;
  assign silent_block_o  = silent_q;

  `RMSM_ASSERT(a_count_cap, count_q <= CNT_W'(COUNT_CAP), "sample count above cap")
  `RMSM_ASSERT_IMP(a_sum_nonzero, count_q != '0, sum_q != '0, "count without sum")
  `RMSM_ASSERT_IMP(a_silent_zero, out_valid_o && silent_block_o, nonzero_count_o == '0,
    "silent result with nonzero count")
  `RMSM_ASSERT_IMP(a_done_state, mul_rsp.done,
    state_q == ST_SQUARE || state_q == ST_LOG || state_q == ST_DMUL,
    "product finished with no consumer waiting")

endmodule

// ===== hw/rtl/rmsm_serial_mul.sv =====
// Shift-add multiplier: one multiplier bit per cycle.
module rmsm_serial_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rmsm_pkg::mul_req_t req_i,
  output rmsm_pkg::mul_rsp_t rsp_o
);
  import rmsm_pkg::*;

  logic [MUL_W-1:0]   a_q;
  logic [2*MUL_W-1:0] p_q;
  logic [4:0]         step_q;
  logic               busy_q;
  logic               done_q;
  logic [MUL_W:0]     upper_sum;

  // Add the multiplicand into the upper half when the current multiplier bit is set.
  assign upper_sum = p_q[0] ? ({1'b0, p_q[2*MUL_W-1:MUL_W]} + {1'b0, a_q})
                            : {1'b0, p_q[2*MUL_W-1:MUL_W]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      p_q    <= '0;
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= !req_i.start && busy_q && (step_q == 5'(MUL_W - 1));
      if (req_i.start) begin
        a_q    <= req_i.a;
        p_q    <= {{MUL_W{1'b0}}, req_i.b};
        step_q <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        p_q    <= {upper_sum, p_q[MUL_W-1:1]};
        step_q <= step_q + 5'd1;
        if (step_q == 5'(MUL_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.product = p_q;

endmodule

// ===== bench/block_rms_sound_level_meter_tb.sv =====
// Self-checking testbench for the block RMS sound level meter: directed table, then random blocks.
module block_rms_sound_level_meter_tb;
  import rmsm_pkg::*;

  localparam int RANDOM_ITEMS  = 930;
  localparam int PHASE_ITEMS   = 120;
  localparam int CALM_FROM     = 800;
  localparam int SETTLE_CYCLES = 64;
  localparam int TAIL_CYCLES   = 200;
  localparam int LONG_HOLD     = 4000;
  localparam int STALL_LIMIT   = 20000;
  localparam int MAX_REPORTS   = 10;

  localparam longint unsigned SUM_TOP = 64'h00FF_FFFF_FFFF_FFFF;
  localparam longint FULL_SCALE_Q16   = longint'(46) << 16;
  localparam longint TEN_LOG10_2_Q24  = 64'sd50504453;

  typedef struct packed {
    logic [15:0] level;
    logic [10:0] count;
    logic        silent;
  } level_result_t;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    reg_idx_e    sel;
    logic [31:0] value;
    logic        last;
    logic        typed;
    logic [15:0] level;
    logic [10:0] count;
    logic        silent;
  } dir_row_t;

  localparam int DIR_ROWS = 28;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // reset settings: silent block, full scale, tiny samples, zero after shift
    '{ROW_ITEM,  REG_SAMPLE_SHIFT, 32'h0000_0000, 1'b1, 1'b1, 16'(20*256),  11'd0, 1'b1},
    '{ROW_ITEM,  REG_SAMPLE_SHIFT, 32'h8000_0000, 1'b1, 1'b1, 16'(120*256), 11'd1, 1'b0},
    '{ROW_ITEM,  REG_SAMPLE_SHIFT, 32'h7FFF_FFFF, 1'b1, 1'b0, 16'd0,        11'd0, 1'b0},
    '{ROW_ITEM,  REG_SAMPLE_SHIFT, 32'h0000_0100, 1'b1, 1'b1, 16'(20*256),  11'd1, 1'b0},
    '{ROW_ITEM,  REG_SAMPLE_SHIFT, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'(20*256),  11'd1, 1'b0},
    '{ROW_ITEM,  REG_SAMPLE_SHIFT, 32'h0000_00FF, 1'b1, 1'b1, 16'(20*256),  11'd0, 1'b1},
    '{ROW_ITEM,  REG_SAMPLE_SHIFT, 32'h1234_5600, 1'b0, 1'b0, 16'd0,        11'd0, 1'b0},
    '{ROW_ITEM,  REG_SAMPLE_SHIFT, 32'hFEDC_BA00, 1'b0, 1'b0, 16'd0,        11'd0, 1'b0},
    '{ROW_ITEM,  REG_SAMPLE_SHIFT, 32'h0000_0000, 1'b0, 1'b0, 16'd0,        11'd0, 1'b0},
    '{ROW_ITEM,  REG_SAMPLE_SHIFT, 32'h00FF_FF00, 1'b1, 1'b0, 16'd0,        11'd0, 1'b0},
    // no shift: squares saturate the sum
    '{ROW_WRITE, REG_SAMPLE_SHIFT, 32'd0,         1'b0, 1'b0, 16'd0,        11'd0, 1'b0},
    '{ROW_ITEM,  REG_SAMPLE_SHIFT, 32'h8000_0000, 1'b0, 1'b0, 16'd0,        11'd0, 1'b0},
    '{ROW_ITEM,  REG_SAMPLE_SHIFT, 32'h7FFF_FFFF, 1'b1, 1'b0, 16'd0,        11'd0, 1'b0},
    // widest shift: positive words vanish, negative ones become -1
    '{ROW_WRITE, REG_SAMPLE_SHIFT, 32'd31,        1'b0, 1'b0, 16'd0,        11'd0, 1'b0},
    '{ROW_ITEM,  REG_SAMPLE_SHIFT, 32'h7FFF_FFFF, 1'b1, 1'b1, 16'(20*256),  11'd0, 1'b1},
    '{ROW_ITEM,  REG_SAMPLE_SHIFT, 32'h8000_0000, 1'b1, 1'b1, 16'(20*256),  11'd1, 1'b0},
    // floor above ceiling: ceiling wins, but a silent block reports the floor
    '{ROW_WRITE, REG_FLOOR,        32'd200,       1'b0, 1'b0, 16'd0,        11'd0, 1'b0},
    '{ROW_WRITE, REG_CEILING,      32'd100,       1'b0, 1'b0, 16'd0,        11'd0, 1'b0},
    '{ROW_ITEM,  REG_SAMPLE_SHIFT, 32'h8000_0000, 1'b1, 1'b1, 16'(100*256), 11'd1, 1'b0},
    '{ROW_ITEM,  REG_SAMPLE_SHIFT, 32'h0000_0000, 1'b1, 1'b1, 16'(200*256), 11'd0, 1'b1},
    // calibration extremes with the clamps wide open
    '{ROW_WRITE, REG_SAMPLE_SHIFT, 32'd8,         1'b0, 1'b0, 16'd0,        11'd0, 1'b0},
    '{ROW_WRITE, REG_CALIBRATION,  32'd255,       1'b0, 1'b0, 16'd0,        11'd0, 1'b0},
    '{ROW_WRITE, REG_FLOOR,        32'd0,         1'b0, 1'b0, 16'd0,        11'd0, 1'b0},
    '{ROW_WRITE, REG_CEILING,      32'd255,       1'b0, 1'b0, 16'd0,        11'd0, 1'b0},
    '{ROW_ITEM,  REG_SAMPLE_SHIFT, 32'h8000_0000, 1'b1, 1'b1, 16'(255*256), 11'd1, 1'b0},
    '{ROW_WRITE, REG_CALIBRATION,  32'd0,         1'b0, 1'b0, 16'd0,        11'd0, 1'b0},
    '{ROW_ITEM,  REG_SAMPLE_SHIFT, 32'h8000_0000, 1'b1, 1'b1, 16'd0,        11'd1, 1'b0},
    '{ROW_ITEM,  REG_SAMPLE_SHIFT, 32'h0000_0100, 1'b1, 1'b1, 16'd0,        11'd1, 1'b0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] sample_word_i = '0;
  logic        last_in_block_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] level_q8_o;
  logic [10:0] nonzero_count_o;
  logic        silent_block_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  block_rms_sound_level_meter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_word_i  (sample_word_i),
    .last_in_block_i(last_in_block_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .level_q8_o     (level_q8_o),
    .nonzero_count_o(nonzero_count_o),
    .silent_block_o (silent_block_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // meter settings and accumulators as the block should hold them
  logic [4:0]       shift_cfg = 5'd8;
  logic [7:0]       cal_cfg   = 8'd120;
  logic [7:0]       floor_cfg = 8'd20;
  logic [7:0]       ceil_cfg  = 8'd120;
  longint unsigned  energy_sum = 0;
  int unsigned      energy_count = 0;

  level_result_t pending_levels [$];
  int  bad_results = 0;
  bit  calm = 1'b0;
  bit  feed_jitter = 1'b1;
  bit  sink_jitter = 1'b1;
  int  long_holds_asked = 0;
  int  long_holds_done = 0;
  int  hold_left = 0;
  int  quiet_cycles = 0;

  // log2 in unsigned Q16: top bit index plus 16 bits found by repeated squaring
  function automatic longint bits_log2(input longint unsigned x);
    int              msb;
    int              i;
    longint unsigned y;
    longint          frac;
    msb = 63;
    frac = 0;
    while (msb > 0 && x[msb] == 1'b0) msb--;
    if (msb >= 31) y = x >> (msb - 31);
    else y = x << (31 - msb);
    for (i = 15; i >= 0; i--) begin
      y = (y * y) >> 31;
      if (y >= 64'h1_0000_0000) begin
        y = y >> 1;
        frac = frac | (longint'(1) << i);
      end
    end
    return (longint'(msb) << 16) | frac;
  endfunction

  // accumulate one word; on the end of a block produce the level and clear
  function automatic bit meter_step(input logic [31:0] word, input logic last,
                                    output level_result_t res);
    logic signed [31:0] smp;
    longint             wide;
    longint unsigned    sq;
    longint             diff;
    longint             prod;
    longint             db_q8;
    longint             lvl;
    res = '0;
    smp = $signed(word) >>> shift_cfg;
    wide = smp;
    if (wide < 0) wide = -wide;
    if (smp != 0 && energy_count < COUNT_CAP) begin
      sq = longint'(wide) * longint'(wide);
      if (sq > SUM_TOP - energy_sum) energy_sum = SUM_TOP;
      else energy_sum = energy_sum + sq;
      energy_count++;
    end
    if (!last) return 1'b0;
    if (energy_count == 0) begin
      res.level = {floor_cfg, 8'h00};
      res.silent = 1'b1;
    end else begin
      diff = bits_log2(energy_sum) - bits_log2(energy_count) - FULL_SCALE_Q16;
      prod = diff * TEN_LOG10_2_Q24;
      db_q8 = (prod + (longint'(1) << 31)) >>> 32;
      lvl = longint'(cal_cfg) * 256 + db_q8;
      if (lvl < longint'(floor_cfg) * 256) lvl = longint'(floor_cfg) * 256;
      if (lvl > longint'(ceil_cfg) * 256) lvl = longint'(ceil_cfg) * 256;
      res.level = lvl[15:0];
      res.count = energy_count[10:0];
    end
    energy_sum = 0;
    energy_count = 0;
    return 1'b1;
  endfunction

  // present one word, hold it until taken, then queue what it should cause
  task automatic offer_word(input logic [31:0] word, input logic last,
                            input bit use_typed, input level_result_t typed_res);
    level_result_t res;
    if (!calm && feed_jitter && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    sample_word_i   <= word;
    last_in_block_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    if (meter_step(word, last, res)) pending_levels.push_back(use_typed ? typed_res : res);
  endtask

  // drop valid, let every queued level arrive, then let the block go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e sel, input logic [7:0] value);
    logic [31:0] data;
    data = $urandom;
    data[7:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (sel)
      REG_SAMPLE_SHIFT: shift_cfg = data[4:0];
      REG_CALIBRATION:  cal_cfg   = data[7:0];
      REG_FLOOR:        floor_cfg = data[7:0];
      REG_CEILING:      ceil_cfg  = data[7:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0, 1:       return 32'h0;
      2, 3, 4, 5: return $urandom;
      6, 7:       return $signed($urandom) >>> $urandom_range(0, 31);
      8:          return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default:    return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic send_block(input int len, input bit silent);
    int          i;
    logic [31:0] word;
    feed_jitter = $urandom_range(0, 3) != 0;
    for (i = 0; i < len; i++) begin
      word = silent ? 32'h0 : pick_word();
      offer_word(word, i == len - 1, 1'b0, '0);
    end
  endtask

  task automatic pick_settings();
    logic [7:0] shift_val;
    case ($urandom_range(0, 5))
      0:       shift_val = 8'd0;
      1:       shift_val = 8'd31;
      2:       shift_val = 8'd16;
      default: shift_val = 8'($urandom_range(4, 12));
    endcase
    write_reg(REG_SAMPLE_SHIFT, shift_val);
    write_reg(REG_CALIBRATION, ($urandom_range(0, 3) == 0) ?
              (($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0) : 8'($urandom_range(60, 180)));
    write_reg(REG_FLOOR, ($urandom_range(0, 3) == 0) ?
              8'($urandom_range(0, 255)) : 8'($urandom_range(0, 40)));
    write_reg(REG_CEILING, ($urandom_range(0, 3) == 0) ?
              8'($urandom_range(0, 255)) : 8'($urandom_range(100, 255)));
  endtask

  // result side: compare each level taken with the oldest one queued
  always @(posedge clk_i) begin
    level_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_levels.size() == 0) begin
        bad_results++;
        if (bad_results <= MAX_REPORTS)
          $display("unexpected result: level %0d count %0d silent %0b",
                   level_q8_o, nonzero_count_o, silent_block_o);
      end else begin
        want = pending_levels.pop_front();
        if (want.level !== level_q8_o || want.count !== nonzero_count_o ||
            want.silent !== silent_block_o) begin
          bad_results++;
          if (bad_results <= MAX_REPORTS)
            $display("mismatch: expected level %0d count %0d silent %0b, got %0d %0d %0b",
                     want.level, want.count, want.silent,
                     level_q8_o, nonzero_count_o, silent_block_o);
        end
      end
    end
  end

  // receiver: short random holds, one long hold when asked
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (long_holds_done < long_holds_asked) begin
      long_holds_done++;
      hold_left = LONG_HOLD - 1;
      out_stall_i <= 1'b1;
    end else if (!calm && sink_jitter && $urandom_range(0, 5) == 0) begin
      hold_left = $urandom_range(0, 4);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
    if ($urandom_range(0, 299) == 0) sink_jitter = !sink_jitter;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable && pready) || !rst_ni)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("no progress for %0d cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int            r;
    int            items_done;
    int            phase_end;
    int            phase;
    int            len;
    level_result_t typed_res;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TABLE[r].kind == ROW_WRITE) begin
        settle();
        write_reg(DIR_TABLE[r].sel, DIR_TABLE[r].value[7:0]);
      end else begin
        typed_res = '{DIR_TABLE[r].level, DIR_TABLE[r].count, DIR_TABLE[r].silent};
        offer_word(DIR_TABLE[r].value, DIR_TABLE[r].last, DIR_TABLE[r].typed, typed_res);
      end
    end

    items_done = 0;
    phase = 0;
    while (items_done < RANDOM_ITEMS) begin
      settle();
      pick_settings();
      // hold the result side off long enough to back the block up
      if (phase == 2) long_holds_asked++;
      phase_end = items_done + PHASE_ITEMS;
      while (items_done < phase_end && items_done < RANDOM_ITEMS) begin
        calm = items_done >= CALM_FROM;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        send_block(len, $urandom_range(0, 19) == 0);
        items_done += len;
      end
      phase++;
    end

    in_valid_i <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (bad_results == 0 && pending_levels.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
